@@ rtl/rrjs_pkg.sv @@
// ----------------------------------------------------------------------------
// rrjs_pkg
// shared types and constants of the round-robin job scheduler
// ----------------------------------------------------------------------------
package rrjs_pkg;

   localparam int ID_W    = 16;
   localparam int TIME_W  = 12;
   localparam int QUANT_W = 12;
   localparam int JOBS_W  = 9;

   localparam logic [QUANT_W-1:0] QUANTUM_RESET = 12'd50;

   // command codes
   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   typedef logic [QUANT_W-1:0] quantum_type;

   typedef struct packed {
      logic              command;
      logic [ID_W-1:0]   job_id;
      logic [TIME_W-1:0] job_time;
   } req_word_type;

   typedef struct packed {
      logic              ran_valid;
      logic [ID_W-1:0]   job_ref;
      logic              job_done;
      logic              requeued;
      logic              enqueue_dropped;
      logic [JOBS_W-1:0] jobs_waiting;
   } rsp_word_type;

   // one queue slot as held in memory
   typedef struct packed {
      logic [ID_W-1:0]   job_id;
      logic [TIME_W-1:0] job_time;
   } entry_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

@@ rtl/rrjs_stream_if.sv @@
// ----------------------------------------------------------------------------
// rrjs_stream_if
// valid/ready channel carrying one word per handshake
// ----------------------------------------------------------------------------
interface rrjs_stream_if #(
   parameter type word_type = logic
);

   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);

endinterface

@@ rtl/rrjs_ram.sv @@
// ----------------------------------------------------------------------------
// rrjs_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rrjs_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/round_robin_job_scheduler.sv @@
// timing: an enqueue or a tick on an empty queue shows its result word in the cycle
// after it is accepted; a tick that runs a job reads the head slot, then shows its word
// from the exec state once the output register is free, and no new request is taken
// meanwhile; throughput: one word per cycle for enqueues and empty ticks, while the
// output is not stalled; reset: clears head, tail, occupancy, slice count and output
// valid, quantum returns to 50; the job memory is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
// round_robin_job_scheduler
// time-slice scheduler over a ring of jobs held in one ram
// ----------------------------------------------------------------------------
module round_robin_job_scheduler #(
   parameter int QUEUE_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   rrjs_stream_if.sink          req_chan,
   rrjs_stream_if.source        rsp_chan,
   input  logic                 csr_we,
   input  rrjs_pkg::quantum_type csr_wdata
);

   import rrjs_pkg::*;

   localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
   localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = $bits(entry_type);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);
   localparam logic [OCC_W-1:0]  FULL_OCC  = OCC_W'(QUEUE_DEPTH);

   // control and pointer registers
   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  head_ff, head_in;
   logic [SLOT_W-1:0]  tail_ff, tail_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [QUANT_W-1:0] slice_ff, slice_in;
   quantum_type        quantum_ff;

   // output register, parts the result side from the request side
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   // memory port signals
   logic               mem_we;
   logic [SLOT_W-1:0]  mem_waddr;
   entry_type          mem_wdata;
   logic               mem_re;
   logic [ENTRY_W-1:0] mem_rdata;

   logic         out_free;
   logic         accept;
   logic         out_load;
   req_word_type req_word;
   entry_type    head_entry;
   logic [TIME_W-1:0]  time_dec;
   logic [QUANT_W-1:0] slice_inc;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
      return (slot == LAST_SLOT) ? '0 : slot + 1'b1;
   endfunction

   // ring storage of queued ids and remaining times
   rrjs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_job_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (head_ff),
      .rd_data (mem_rdata)
   );

   // the output word may be replaced when empty or taken this cycle
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign accept         = req_chan.valid && req_chan.ready;
   assign req_word       = req_chan.word;

   // head job as read from the ram in the idle state, with one unit consumed
   assign head_entry = entry_type'(mem_rdata);
   assign time_dec   = (head_entry.job_time != '0) ? head_entry.job_time - 1'b1 : '0;
   assign slice_inc  = slice_ff + 1'b1;

   // next state: a tick on a non-empty queue waits in the exec state for the head read and a free output
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_word.command == CMD_TICK && occ_ff != '0) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      occ_in      = occ_ff;
      slice_in    = slice_ff;
      mem_we      = 1'b0;
      mem_waddr   = tail_ff;
      mem_wdata   = '0;
      mem_re      = 1'b0;
      out_load    = 1'b0;
      rsp_word_in = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_word.command == CMD_ENQUEUE) begin
                  out_load = 1'b1;
                  if (req_word.job_time == '0) begin
                     // zero-time job finishes at once and is never stored
                     rsp_word_in.job_ref  = req_word.job_id;
                     rsp_word_in.job_done = 1'b1;
                  end else if (occ_ff >= FULL_OCC) begin
                     rsp_word_in.enqueue_dropped = 1'b1;
                  end else begin
                     mem_we             = 1'b1;
                     mem_waddr          = tail_ff;
                     mem_wdata.job_id   = req_word.job_id;
                     mem_wdata.job_time = req_word.job_time;
                     tail_in            = next_slot(tail_ff);
                     occ_in             = occ_ff + 1'b1;
                  end
               end else if (occ_ff == '0) begin
                  // empty queue idles, all fields zero
                  out_load = 1'b1;
               end else begin
                  // fetch the head job, finish in the exec state
                  mem_re = 1'b1;
               end
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               out_load              = 1'b1;
               rsp_word_in.ran_valid = 1'b1;
               rsp_word_in.job_ref   = head_entry.job_id;
               if (time_dec == '0) begin
                  // finished: done wins over requeue on the last slice unit
                  rsp_word_in.job_done = 1'b1;
                  head_in              = next_slot(head_ff);
                  occ_in               = occ_ff - 1'b1;
                  slice_in             = '0;
               end else if (slice_inc >= quantum_ff) begin
                  // slice used up: move to tail with a fresh slice
                  rsp_word_in.requeued = 1'b1;
                  mem_we               = 1'b1;
                  mem_waddr            = tail_ff;
                  mem_wdata.job_id     = head_entry.job_id;
                  mem_wdata.job_time   = time_dec;
                  head_in              = next_slot(head_ff);
                  tail_in              = next_slot(tail_ff);
                  slice_in             = '0;
               end else begin
                  // keep running, write back remaining time in place
                  mem_we             = 1'b1;
                  mem_waddr          = head_ff;
                  mem_wdata.job_id   = head_entry.job_id;
                  mem_wdata.job_time = time_dec;
                  slice_in           = slice_inc;
               end
            end
         end
         default: ;
      endcase

      rsp_word_in.jobs_waiting = JOBS_W'(occ_in);
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         slice_ff     <= '0;
         quantum_ff   <= QUANTUM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         slice_ff     <= slice_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            quantum_ff <= csr_wdata;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.word  = rsp_word_ff;

endmodule

@@ verif/tb_round_robin_job_scheduler.sv @@
// ----------------------------------------------------------------------------
// tb_round_robin_job_scheduler
// self-checking bench for the round-robin job scheduler: a cycle-free model of
// the job ring predicts one response word per request word, and every
// response is compared field by field in arrival order
// ----------------------------------------------------------------------------
module tb_round_robin_job_scheduler;

   import rrjs_pkg::*;

   localparam int QUEUE_DEPTH = 256;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;

   logic        clock;
   logic        reset;
   logic        csr_we;
   quantum_type csr_wdata;

   rrjs_stream_if #(.word_type(req_word_type)) req_chan ();
   rrjs_stream_if #(.word_type(rsp_word_type)) rsp_chan ();

   round_robin_job_scheduler #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // scheduler model state
   logic [ID_W-1:0]   ring_id   [QUEUE_DEPTH];
   logic [TIME_W-1:0] ring_time [QUEUE_DEPTH];
   int                head_pos;
   int                tail_pos;
   int                jobs_held;
   logic [QUANT_W-1:0] slice_count;
   quantum_type       quantum_model;

   // response words still owed by the block, oldest first
   rsp_word_type expected_rsps [$];

   int  errors;
   int  cycle_count;
   int  words_sent;
   int  words_checked;
   int  drops_seen;
   int  requeues_seen;
   int  finishes_seen;
   int  idle_ticks_seen;
   int  stall_left;
   bit  idle_on;

   // model of one request word; updates the ring and returns the response
   function automatic rsp_word_type schedule_step(req_word_type w);
      rsp_word_type      r;
      logic [ID_W-1:0]   hid;
      logic [TIME_W-1:0] ht;
      r = '0;
      if (w.command == CMD_ENQUEUE) begin
         if (w.job_time == '0) begin
            // zero-time job never enters the ring, it is reported finished at once
            r.job_ref  = w.job_id;
            r.job_done = 1'b1;
         end else if (jobs_held >= QUEUE_DEPTH) begin
            r.enqueue_dropped = 1'b1;
         end else begin
            ring_id[tail_pos]   = w.job_id;
            ring_time[tail_pos] = w.job_time;
            tail_pos            = (tail_pos + 1) % QUEUE_DEPTH;
            jobs_held++;
         end
      end else if (jobs_held != 0) begin
         hid         = ring_id[head_pos];
         ht          = ring_time[head_pos];
         r.ran_valid = 1'b1;
         r.job_ref   = hid;
         if (ht != '0) ht = ht - 1'b1;
         slice_count = slice_count + 1'b1;
         if (ht == '0) begin
            // finishing wins over a used-up slice
            r.job_done  = 1'b1;
            head_pos    = (head_pos + 1) % QUEUE_DEPTH;
            jobs_held--;
            slice_count = '0;
         end else if (slice_count >= quantum_model) begin
            // slice used up: head goes to the tail, a zero quantum acts as one
            r.requeued          = 1'b1;
            head_pos            = (head_pos + 1) % QUEUE_DEPTH;
            ring_id[tail_pos]   = hid;
            ring_time[tail_pos] = ht;
            tail_pos            = (tail_pos + 1) % QUEUE_DEPTH;
            slice_count         = '0;
         end else begin
            ring_time[head_pos] = ht;
         end
      end
      r.jobs_waiting = jobs_held[JOBS_W-1:0];
      return r;
   endfunction

   // clock, period 20
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // every input known from time zero
   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      req_chan.valid = 1'b0;
      req_chan.word  = '0;
      rsp_chan.ready = 1'b0;
      stall_left    = 0;
      idle_on       = 1'b1;
      errors        = 0;
      cycle_count   = 0;
      words_sent    = 0;
      words_checked = 0;
      drops_seen    = 0;
      requeues_seen = 0;
      finishes_seen = 0;
      idle_ticks_seen = 0;
      head_pos      = 0;
      tail_pos      = 0;
      jobs_held     = 0;
      slice_count   = '0;
      quantum_model = QUANTUM_RESET;
   end

   // receiver side: random stall bursts while idling is on
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left = $urandom_range(0, 4);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // rising edge: check responses, track register writes, predict accepted requests
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still owed",
                  cycle_count, expected_rsps.size());
         $display("*** FAILED ***");
         $finish;
      end
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_rsps.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("unexpected response word %h", rsp_chan.word);
            end else begin
               rsp_word_type exp_w;
               rsp_word_type act_w;
               exp_w = expected_rsps.pop_front();
               act_w = rsp_chan.word;
               words_checked++;
               if (act_w.ran_valid       !== exp_w.ran_valid       ||
                   act_w.job_ref         !== exp_w.job_ref         ||
                   act_w.job_done        !== exp_w.job_done        ||
                   act_w.requeued        !== exp_w.requeued        ||
                   act_w.enqueue_dropped !== exp_w.enqueue_dropped ||
                   act_w.jobs_waiting    !== exp_w.jobs_waiting) begin
                  errors++;
                  if (errors <= MAX_REPORTS) begin
                     $display("mismatch on response %0d: expected ran=%b ref=%h done=%b req=%b drop=%b wait=%0d",
                              words_checked,
                              exp_w.ran_valid, exp_w.job_ref, exp_w.job_done,
                              exp_w.requeued, exp_w.enqueue_dropped, exp_w.jobs_waiting);
                     $display("   got ran=%b ref=%h done=%b req=%b drop=%b wait=%0d",
                              act_w.ran_valid, act_w.job_ref, act_w.job_done,
                              act_w.requeued, act_w.enqueue_dropped, act_w.jobs_waiting);
                  end
               end
            end
         end
         if (csr_we)
            quantum_model = csr_wdata;
         if (req_chan.valid && req_chan.ready) begin
            rsp_word_type pred_w;
            pred_w = schedule_step(req_chan.word);
            expected_rsps.push_back(pred_w);
            words_sent++;
            if (pred_w.enqueue_dropped) drops_seen++;
            if (pred_w.requeued)        requeues_seen++;
            if (pred_w.job_done)        finishes_seen++;
            if (req_chan.word.command == CMD_TICK && !pred_w.ran_valid) idle_ticks_seen++;
         end
      end
   end

   // send one request word; called and returns at a falling edge
   task automatic send_word(logic cmd, logic [ID_W-1:0] id, logic [TIME_W-1:0] jt);
      req_word_type w;
      int           gap;
      w.command  = cmd;
      w.job_id   = id;
      w.job_time = jt;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.word  <= w;
      do
         @(posedge clock);
      while (!req_chan.ready);
      @(negedge clock);
   endtask

   // hold off the sender until every owed response has come back
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
   endtask

   // register write only while the block is idle
   task automatic set_quantum(quantum_type q);
      drain_results();
      repeat (3) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= q;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // hand-picked words: empty tick, zero-time jobs, id extremes, slice rules
   task automatic test_directed();
      send_word(CMD_TICK,    16'h0000, 12'h000);   // idle tick on empty ring
      send_word(CMD_ENQUEUE, 16'hFFFF, 12'h000);   // zero-time job, max id
      send_word(CMD_ENQUEUE, 16'h0000, 12'h000);   // zero-time job, id zero
      send_word(CMD_ENQUEUE, 16'hFFFF, 12'h001);
      send_word(CMD_TICK,    16'hFFFF, 12'hFFF);   // payload ignored on tick
      send_word(CMD_ENQUEUE, 16'h1234, 12'hFFF);   // longest job
      send_word(CMD_TICK,    16'h0000, 12'h000);
      set_quantum(12'd2);
      send_word(CMD_TICK,    16'h0000, 12'h000);   // lone job moves to its own tail
      send_word(CMD_ENQUEUE, 16'h00A5, 12'h002);
      send_word(CMD_TICK,    16'h0000, 12'h000);
      send_word(CMD_TICK,    16'h0000, 12'h000);   // slice used, requeue
      send_word(CMD_TICK,    16'h0000, 12'h000);
      send_word(CMD_TICK,    16'h0000, 12'h000);   // done on last unit of slice
      set_quantum(12'd0);
      send_word(CMD_TICK,    16'h0000, 12'h000);   // zero quantum acts as one
      send_word(CMD_TICK,    16'h0000, 12'h000);
      send_word(CMD_ENQUEUE, 16'h5A5A, 12'h001);
      send_word(CMD_TICK,    16'h0000, 12'h000);
      send_word(CMD_TICK,    16'h0000, 12'h000);
      set_quantum(12'd4095);
      send_word(CMD_ENQUEUE, 16'hC3C3, 12'h800);
      send_word(CMD_TICK,    16'h0000, 12'h000);
      send_word(CMD_TICK,    16'h0000, 12'h000);
   endtask

   // fill the ring to the brim, push past it, then drain what was added
   task automatic test_full_queue();
      int held_before;
      set_quantum(12'd1);
      held_before = jobs_held;
      while (jobs_held < QUEUE_DEPTH)
         send_word(CMD_ENQUEUE, ID_W'($urandom), 12'd1);
      send_word(CMD_ENQUEUE, ID_W'($urandom), 12'd7);      // dropped
      send_word(CMD_ENQUEUE, ID_W'($urandom), 12'hFFF);    // dropped
      send_word(CMD_ENQUEUE, ID_W'($urandom), 12'd0);      // zero-time still reported
      send_word(CMD_TICK,    16'h0000, 12'h000);           // long head job requeues
      send_word(CMD_ENQUEUE, ID_W'($urandom), 12'd3);      // still full, dropped
      send_word(CMD_TICK,    16'h0000, 12'h000);
      send_word(CMD_TICK,    16'h0000, 12'h000);
      while (jobs_held > held_before)
         send_word(CMD_TICK, ID_W'($urandom), TIME_W'($urandom));
   endtask

   // random mix of enqueues and ticks under one quantum
   task automatic test_random_mix(quantum_type q, int count);
      int               pick;
      logic [TIME_W-1:0] jt;
      set_quantum(q);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 79) == 0)
            drain_results();
         if ($urandom_range(0, 99) < 58) begin
            send_word(CMD_TICK, ID_W'($urandom), TIME_W'($urandom));
         end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
               jt = '0;
            else if (pick < 8)
               jt = TIME_W'($urandom_range(1, 8));
            else
               jt = TIME_W'($urandom_range(1, 4095));
            send_word(CMD_ENQUEUE, ID_W'($urandom), jt);
         end
      end
   endtask

   initial begin
      int wait_cycles;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_full_queue();
      test_random_mix(12'd1, 150);
      test_random_mix(12'd4095, 20);
      test_random_mix(QUANT_W'($urandom_range(2, 200)), 150);
      test_random_mix(12'd7, 100);
      test_random_mix(QUANTUM_RESET, 60);
      // closing stretch with both sides running flat out
      idle_on = 1'b0;
      test_random_mix(QUANT_W'($urandom_range(1, 16)), 130);

      req_chan.valid <= 1'b0;
      wait_cycles = 0;
      while (expected_rsps.size() != 0 && wait_cycles < 2000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (4) @(negedge clock);
      if (expected_rsps.size() != 0) begin
         $display("%0d response words never arrived", expected_rsps.size());
         errors += expected_rsps.size();
      end

      $display("sent %0d request words, checked %0d response words, %0d errors",
               words_sent, words_checked, errors);
      $display("saw %0d finishes, %0d requeues, %0d drops, %0d idle ticks",
               finishes_seen, requeues_seen, drops_seen, idle_ticks_seen);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
